// File: src/brt_pkg.sv
// Shared types and constants of the bidirectional route table.
// Used by bidirectional_route_table and brt_match; depends on nothing.
package brt_pkg;

	localparam int TableSlotsDef = 16;
	localparam int IdBitsDef     = 8;
	localparam int QueueBitsDef  = 10;
	localparam int HANDLER_W     = 4;
	localparam int STATUS_W      = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_DUPLICATE    = 3'd1,
		ST_FULL         = 3'd2,
		ST_NOT_FOUND    = 3'd3,
		ST_LOOP_REFUSED = 3'd4
	} status_t;

	typedef enum logic {
		REQ_ADD    = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// Compare results of one stored record against the current request.
	typedef struct packed {
		logic dup;
		logic fwd;
		logic bwd;
	} match_t;

endpackage

// File: src/bidirectional_route_table.sv
// Top level of the bidirectional route table: request sequencer, slot valid
// bits and result register. Depends on brt_pkg, brt_ram and brt_match.
//
// Usage: one request beat enters on the in channel (valid/ready) and exactly
// one result beat leaves on the out channel (valid/ready). An add stores a
// two-way connection in the lowest free slot unless a stored entry already
// matches it; a lookup returns the peer queue and the handler for that
// direction, or the sender's own queue for an allowed loopback.
// Requests are handled one at a time. Each scan reads the record memory one
// slot per cycle; an add scans every slot unless it finds a duplicate, a
// lookup stops at the first slot that hits, and a loopback lookup skips
// the scan. The single read port of the record memory sets this rate;
// in_ready returns at the edge that loads the result register.
// The result register frees the sequencer while the receiver stalls; a
// second result waits in the sequencer until that register is taken.
// Reset clears the slot valid bits, so the table is empty at once with no
// clearing pass; the record memory itself is not reset.
module bidirectional_route_table #(
	parameter int TABLE_SLOTS = brt_pkg::TableSlotsDef,
	parameter int ID_BITS     = brt_pkg::IdBitsDef,
	parameter int QUEUE_BITS  = brt_pkg::QueueBitsDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic [ID_BITS-1:0]              first_instance,
	input  logic [ID_BITS-1:0]              first_component,
	input  logic [QUEUE_BITS-1:0]           first_queue,
	input  logic [ID_BITS-1:0]              second_instance,
	input  logic [ID_BITS-1:0]              second_component,
	input  logic [QUEUE_BITS-1:0]           second_queue,
	input  logic [brt_pkg::HANDLER_W-1:0]   handler_forward,
	input  logic [brt_pkg::HANDLER_W-1:0]   handler_backward,
	input  logic                            loopback_ok,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [brt_pkg::STATUS_W-1:0]    status,
	output logic [QUEUE_BITS-1:0]           dest_queue,
	output logic [brt_pkg::HANDLER_W-1:0]   handler_id
);

	import brt_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int REC_W = 4 * ID_BITS + 2 * QUEUE_BITS + 2 * HANDLER_W;
	localparam logic [IDX_W-1:0] LastIdx = IDX_W'(TABLE_SLOTS - 1);

	state_t state_q, state_d;

	// Request held for the whole scan.
	logic                  req_type_q;
	logic [ID_BITS-1:0]    req_i1_q, req_c1_q, req_i2_q, req_c2_q;
	logic [QUEUE_BITS-1:0] req_q1_q, req_q2_q;
	logic [HANDLER_W-1:0]  req_hf_q, req_hb_q;

	logic [TABLE_SLOTS-1:0] used_q;
	logic [IDX_W-1:0]       cnt_q;
	logic                   issued_all_q;
	logic                   chk_vld_s1;
	logic [IDX_W-1:0]       chk_idx_s1;
	logic                   free_fnd_q;
	logic [IDX_W-1:0]       free_idx_q;

	status_t               res_status_q;
	logic [QUEUE_BITS-1:0] res_queue_q;
	logic [HANDLER_W-1:0]  res_handler_q;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [QUEUE_BITS-1:0] out_queue_q;
	logic [HANDLER_W-1:0]  out_handler_q;

	logic                  accept;
	logic                  loopback;
	logic                  out_free;
	logic                  issue;
	logic                  fin;
	logic                  load_out;
	logic                  wr_en;
	logic                  slot_used;
	logic                  is_last;
	status_t               fin_status;
	logic [QUEUE_BITS-1:0] fin_queue;
	logic [HANDLER_W-1:0]  fin_handler;

	logic [REC_W-1:0]      rd_data;
	logic [REC_W-1:0]      wr_data;
	logic [ID_BITS-1:0]    rd_inst_a, rd_comp_a, rd_inst_b, rd_comp_b;
	logic [QUEUE_BITS-1:0] rd_queue_a, rd_queue_b;
	logic [HANDLER_W-1:0]  rd_h_fwd, rd_h_bwd;
	match_t                mt;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign loopback = (req_type == REQ_LOOKUP) && (first_component == second_component);
	assign out_free = !out_valid_q || out_ready;

	assign {rd_inst_a, rd_comp_a, rd_queue_a, rd_inst_b, rd_comp_b, rd_queue_b,
		rd_h_fwd, rd_h_bwd} = rd_data;
	assign wr_data = {req_i1_q, req_c1_q, req_q1_q, req_i2_q, req_c2_q, req_q2_q,
		req_hf_q, req_hb_q};

	assign slot_used = used_q[chk_idx_s1];
	assign is_last   = (chk_idx_s1 == LastIdx);

	brt_ram #(
		.WIDTH (REC_W),
		.DEPTH (TABLE_SLOTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (free_idx_q),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (cnt_q),
		.rd_data (rd_data)
	);

	brt_match #(
		.ID_BITS (ID_BITS)
	) u_match (
		.rec_inst_a (rd_inst_a),
		.rec_comp_a (rd_comp_a),
		.rec_inst_b (rd_inst_b),
		.rec_comp_b (rd_comp_b),
		.req_inst1  (req_i1_q),
		.req_comp1  (req_c1_q),
		.req_inst2  (req_i2_q),
		.req_comp2  (req_c2_q),
		.result     (mt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		issue       = 1'b0;
		fin         = 1'b0;
		fin_status  = ST_OK;
		fin_queue   = '0;
		fin_handler = '0;
		load_out    = 1'b0;
		wr_en       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = loopback ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				issue = !issued_all_q;
				if (chk_vld_s1) begin
					if (req_type_q == REQ_ADD) begin
						if (slot_used && mt.dup) begin
							fin        = 1'b1;
							fin_status = ST_DUPLICATE;
						end else if (is_last) begin
							fin        = 1'b1;
							fin_status = (free_fnd_q || !slot_used) ? ST_OK : ST_FULL;
						end
					end else begin
						// Within one slot the forward direction wins.
						if (slot_used && mt.fwd) begin
							fin         = 1'b1;
							fin_queue   = rd_queue_b;
							fin_handler = rd_h_fwd;
						end else if (slot_used && mt.bwd) begin
							fin         = 1'b1;
							fin_queue   = rd_queue_a;
							fin_handler = rd_h_bwd;
						end else if (is_last) begin
							fin        = 1'b1;
							fin_status = ST_NOT_FOUND;
						end
					end
				end
				if (fin) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					wr_en    = (req_type_q == REQ_ADD) && (res_status_q == ST_OK);
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req_type;
			req_i1_q   <= first_instance;
			req_c1_q   <= first_component;
			req_q1_q   <= first_queue;
			req_i2_q   <= second_instance;
			req_c2_q   <= second_component;
			req_q2_q   <= second_queue;
			req_hf_q   <= handler_forward;
			req_hb_q   <= handler_backward;
		end
	end

	// Scan counters and the compare stage that follows the memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			issued_all_q <= 1'b0;
			chk_vld_s1   <= 1'b0;
			chk_idx_s1   <= '0;
			free_fnd_q   <= 1'b0;
			free_idx_q   <= '0;
		end else begin
			chk_vld_s1 <= issue && !fin;
			if (accept) begin
				cnt_q        <= '0;
				issued_all_q <= 1'b0;
				free_fnd_q   <= 1'b0;
			end else if (issue) begin
				chk_idx_s1 <= cnt_q;
				if (cnt_q == LastIdx) begin
					issued_all_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (state_q == S_SCAN && chk_vld_s1 && !slot_used && !free_fnd_q) begin
				free_fnd_q <= 1'b1;
				free_idx_q <= chk_idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (wr_en) begin
			used_q[free_idx_q] <= 1'b1;
		end
	end

	// Result waiting in the sequencer.
	always_ff @(posedge clk) begin
		if (accept && loopback) begin
			res_status_q  <= loopback_ok ? ST_OK : ST_LOOP_REFUSED;
			res_queue_q   <= loopback_ok ? first_queue : '0;
			res_handler_q <= '0;
		end else if (fin) begin
			res_status_q  <= fin_status;
			res_queue_q   <= fin_queue;
			res_handler_q <= fin_handler;
		end
	end

	// Output register: holds the beat while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q  <= res_status_q;
			out_queue_q   <= res_queue_q;
			out_handler_q <= res_handler_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign dest_queue = out_queue_q;
	assign handler_id = out_handler_q;

	// A record is only ever written into a slot that is still free.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !used_q[free_idx_q])
		else $error("record written into a used slot");

	// A successful add always has a free slot recorded by the scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && req_type_q == REQ_ADD && res_status_q == ST_OK)
		|-> free_fnd_q)
		else $error("add finished ok without a free slot");

	// A new result beat appears only after the sequencer finished a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_DONE))
		else $error("result beat without a finished request");

	// Failed requests carry no queue and no handler.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_OK)
		|-> (out_queue_q == '0 && out_handler_q == '0))
		else $error("nonzero payload on a failed request");

endmodule

// File: src/brt_ram.sv
// Record memory of the route table: one write port, one read port.
// Read data is registered. Uses no package items.
module brt_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: src/brt_match.sv
// Compares one record read from the table against the pending request.
// Depends on brt_pkg for the match_t result type.
module brt_match #(
	parameter int ID_BITS = 8
) (
	input  logic [ID_BITS-1:0] rec_inst_a,
	input  logic [ID_BITS-1:0] rec_comp_a,
	input  logic [ID_BITS-1:0] rec_inst_b,
	input  logic [ID_BITS-1:0] rec_comp_b,
	input  logic [ID_BITS-1:0] req_inst1,
	input  logic [ID_BITS-1:0] req_comp1,
	input  logic [ID_BITS-1:0] req_inst2,
	input  logic [ID_BITS-1:0] req_comp2,
	output brt_pkg::match_t    result
);

	import brt_pkg::*;

	logic fwd_hit;
	logic swap_hit;
	logic bwd_hit;

	// Forward: the record's first endpoint is the sender and its second
	// component is the wanted destination.
	assign fwd_hit  = (rec_inst_a == req_inst1) && (rec_comp_b == req_comp2);
	// An add also collides when the new pair appears in the other order.
	assign swap_hit = (rec_inst_a == req_inst2) && (rec_comp_b == req_comp1);
	assign bwd_hit  = (rec_inst_b == req_inst1) && (rec_comp_a == req_comp2);

	always_comb begin
		result.dup = fwd_hit || swap_hit;
		result.fwd = fwd_hit;
		result.bwd = bwd_hit;
	end

endmodule
